// ----- rtl/bb3_pkg.sv -----
// ============================================================================
// bb3_pkg: shared types and constants of the 3x3 box blur
// Pixel, window and queue item types, register indexes, reset values and the
// reciprocal table used for the edge-normalized mean.
// ============================================================================
`default_nettype none

package bb3_pkg;

    // Pixel layout: blue in [7:0], green in [15:8], red in [23:16].
    localparam int PIX_W = 24;
    localparam int CH_W  = 8;
    localparam int WIN_N = 9;

    typedef logic [PIX_W-1:0] t_pixel;

    // 3x3 window, row-major, top row first, left column first.
    typedef t_pixel [WIN_N-1:0] t_window;

    // Which sides of the neighborhood fall outside the image.
    typedef struct packed {
        logic top;
        logic bottom;
        logic left;
        logic right;
    } t_edges;

    // One blur job handed from the front end to the back end.
    typedef struct packed {
        t_window pix;
        t_edges  edges;
    } t_blur_item;

    // Job queue geometry.
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;
    localparam int Q_CW    = 3;

    typedef struct packed {
        logic       valid;
        t_blur_item item;
    } t_q_push;

    typedef struct packed {
        logic [Q_CW-1:0] count;
        logic            not_empty;
    } t_q_status;

    // Configuration port.
    localparam int CFG_INDEX_W  = 1;
    localparam int CFG_DATA_W   = 13;
    localparam int WIDTH_REG_W  = 12;
    localparam int HEIGHT_REG_W = 13;

    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

    localparam logic [WIDTH_REG_W-1:0]  IMAGE_WIDTH_RST  = 12'd640;
    localparam logic [HEIGHT_REG_W-1:0] IMAGE_HEIGHT_RST = 13'd480;

    // Input item commands.
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    // Mean arithmetic: a channel sum of up to nine pixels, the count of
    // counted pixels, and a 2^15-scaled reciprocal of that count.
    localparam int SUM_W       = 12;
    localparam int CNT_W       = 4;
    localparam int RECIP_W     = 16;
    localparam int RECIP_SHIFT = 15;
    localparam int PROD_W      = SUM_W + RECIP_W;

    // Reciprocals are rounded up; for sums of at most nine 8-bit pixels the
    // truncated product equals the exact quotient for every count in use.
    function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] n);
        logic [RECIP_W-1:0] k;
        unique case (n)
            4'd1:    k = 16'd32768;
            4'd2:    k = 16'd16384;
            4'd3:    k = 16'd10923;
            4'd4:    k = 16'd8192;
            4'd6:    k = 16'd5462;
            4'd9:    k = 16'd3641;
            default: k = 16'd32768;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/bb3_front.sv -----
// ============================================================================
// bb3_front: pixel intake, line stores and window
// Accepts pixel and flush items, tracks input and output positions, keeps the
// two line stores and the 3x3 window, and hands each emitting item to the
// job queue together with the edges that bound its neighborhood.
// ============================================================================
`default_nettype none

module bb3_front #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [bb3_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [bb3_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic                                i_cmd,
    input  logic [bb3_pkg::CH_W-1:0]            i_in_blue,
    input  logic [bb3_pkg::CH_W-1:0]            i_in_green,
    input  logic [bb3_pkg::CH_W-1:0]            i_in_red,
    input  bb3_pkg::t_q_status                  i_q_status,
    output bb3_pkg::t_q_push                    o_push
);

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int W_W    = $clog2(MAX_WIDTH + 1);
    localparam int CW     = W_W + 1;
    localparam int IROW_W = $clog2(MAX_HEIGHT + 2);
    localparam int OROW_W = $clog2(MAX_HEIGHT);
    localparam int H_W    = $clog2(MAX_HEIGHT + 1);
    localparam int HC     = H_W + 1;

    localparam logic [IROW_W-1:0] ROW_SAT = IROW_W'(MAX_HEIGHT + 1);

    // Configuration registers.
    logic [bb3_pkg::WIDTH_REG_W-1:0]  r_image_width;
    logic [bb3_pkg::HEIGHT_REG_W-1:0] r_image_height;

    // Position counters.
    logic [COL_W-1:0]  r_in_col,  n_in_col;
    logic [IROW_W-1:0] r_in_row,  n_in_row;
    logic [COL_W-1:0]  r_out_col, n_out_col;
    logic [OROW_W-1:0] r_out_row, n_out_row;

    // Line stores: a holds the previous input row, b the row before it.
    bb3_pkg::t_pixel r_store_a [MAX_WIDTH];
    bb3_pkg::t_pixel r_store_b [MAX_WIDTH];
    bb3_pkg::t_pixel r_rd_top;
    bb3_pkg::t_pixel r_rd_mid;

    // Same-address forwarding from the write stage.
    logic            r_byp;
    bb3_pkg::t_pixel r_byp_top;
    bb3_pkg::t_pixel r_byp_mid;

    // Window stage.
    logic              r_s1_valid;
    logic              r_s1_emit;
    bb3_pkg::t_edges   r_s1_edges;
    logic [COL_W-1:0]  r_s1_col;
    bb3_pkg::t_pixel   r_s1_px;
    bb3_pkg::t_window  r_win;
    bb3_pkg::t_window  n_win;

    logic              accept;
    logic [W_W-1:0]    w_eff;
    logic [H_W-1:0]    h_eff;
    logic              emit;
    logic              col_wrap;
    bb3_pkg::t_edges   edges;
    logic              eof;
    bb3_pkg::t_pixel   px;
    bb3_pkg::t_pixel   top_eff;
    bb3_pkg::t_pixel   mid_eff;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= bb3_pkg::IMAGE_WIDTH_RST;
            r_image_height <= bb3_pkg::IMAGE_HEIGHT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                bb3_pkg::CFG_IMAGE_WIDTH:
                    r_image_width <= i_cfg_data[bb3_pkg::WIDTH_REG_W-1:0];
                bb3_pkg::CFG_IMAGE_HEIGHT:
                    r_image_height <= i_cfg_data[bb3_pkg::HEIGHT_REG_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective image size: zero acts as one, large values clamp to the limit.
    always_comb begin
        if (r_image_width == '0) begin
            w_eff = W_W'(1);
        end else if (32'(r_image_width) > 32'(MAX_WIDTH)) begin
            w_eff = W_W'(MAX_WIDTH);
        end else begin
            w_eff = W_W'(r_image_width);
        end
        if (r_image_height == '0) begin
            h_eff = H_W'(1);
        end else if (32'(r_image_height) > 32'(MAX_HEIGHT)) begin
            h_eff = H_W'(MAX_HEIGHT);
        end else begin
            h_eff = H_W'(r_image_height);
        end
    end

    // Hold off the sender while the queue could not take the item in flight
    // plus the next one.
    assign o_stall = (i_q_status.count + bb3_pkg::Q_CW'(r_s1_valid && r_s1_emit))
                     >= bb3_pkg::Q_CW'(bb3_pkg::Q_DEPTH);
    assign accept  = i_valid && !o_stall;

    // Flush items push a zero pixel.
    always_comb begin
        unique case (i_cmd)
            bb3_pkg::CMD_PIXEL: px = {i_in_red, i_in_green, i_in_blue};
            bb3_pkg::CMD_FLUSH: px = '0;
            default:            px = '0;
        endcase
    end

    // Emission decision, output edges and next counter values.
    always_comb begin
        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;

        emit = (r_in_row >= IROW_W'(2)) || ((r_in_row == IROW_W'(1)) && (r_in_col != '0));
        col_wrap = (CW'(r_in_col) + CW'(1)) >= CW'(w_eff);

        edges.top    = (r_out_row == '0);
        edges.bottom = (HC'(r_out_row) + HC'(1)) >= HC'(h_eff);
        edges.left   = (r_out_col == '0);
        edges.right  = (CW'(r_out_col) + CW'(1)) >= CW'(w_eff);
        eof          = edges.bottom && edges.right;

        if (col_wrap) begin
            n_in_col = '0;
            if (r_in_row < ROW_SAT) begin
                n_in_row = r_in_row + IROW_W'(1);
            end
        end else begin
            n_in_col = r_in_col + COL_W'(1);
        end

        if (emit) begin
            if (eof) begin
                n_in_col  = '0;
                n_in_row  = '0;
                n_out_col = '0;
                n_out_row = '0;
            end else if (edges.right) begin
                n_out_col = '0;
                n_out_row = r_out_row + OROW_W'(1);
            end else begin
                n_out_col = r_out_col + COL_W'(1);
            end
        end
    end

    // Counters and the window stage's valid advance on each transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col   <= '0;
            r_in_row   <= '0;
            r_out_col  <= '0;
            r_out_row  <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
            if (accept) begin
                r_in_col  <= n_in_col;
                r_in_row  <= n_in_row;
                r_out_col <= n_out_col;
                r_out_row <= n_out_row;
            end
        end
    end

    // Item data for the window stage.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_emit  <= emit;
            r_s1_edges <= edges;
            r_s1_col   <= r_in_col;
            r_s1_px    <= px;
            r_byp      <= r_s1_valid && (r_s1_col == r_in_col);
            r_byp_top  <= mid_eff;
            r_byp_mid  <= r_s1_px;
        end
    end

    // Line store read on transfer, write in the following cycle from the window stage.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd_top <= r_store_b[r_in_col];
            r_rd_mid <= r_store_a[r_in_col];
        end
        if (r_s1_valid) begin
            r_store_b[r_s1_col] <= mid_eff;
            r_store_a[r_s1_col] <= r_s1_px;
        end
    end

    // A write to the same column in the read cycle is forwarded.
    assign top_eff = r_byp ? r_byp_top : r_rd_top;
    assign mid_eff = r_byp ? r_byp_mid : r_rd_mid;

    // Shift the window one column left and bring in the new column.
    always_comb begin
        n_win    = r_win;
        n_win[0] = r_win[1];
        n_win[1] = r_win[2];
        n_win[2] = top_eff;
        n_win[3] = r_win[4];
        n_win[4] = r_win[5];
        n_win[5] = mid_eff;
        n_win[6] = r_win[7];
        n_win[7] = r_win[8];
        n_win[8] = r_s1_px;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else if (r_s1_valid) begin
            r_win <= n_win;
        end
    end

    // Hand emitting items to the queue.
    always_comb begin
        o_push.valid      = r_s1_valid && r_s1_emit;
        o_push.item.pix   = n_win;
        o_push.item.edges = r_s1_edges;
    end

endmodule

`default_nettype wire

// ----- rtl/bb3_queue.sv -----
// ============================================================================
// bb3_queue: job queue between front end and back end
// A small register FIFO of blur jobs so that an output stall does not reach
// back into the line store pipeline at once.
// ============================================================================
`default_nettype none

module bb3_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  bb3_pkg::t_q_push     i_push,
    input  logic                 i_pop,
    output bb3_pkg::t_q_status   o_status,
    output bb3_pkg::t_blur_item  o_item
);

    bb3_pkg::t_blur_item          r_mem [bb3_pkg::Q_DEPTH];
    logic [bb3_pkg::Q_AW-1:0]     r_wr_ptr;
    logic [bb3_pkg::Q_AW-1:0]     r_rd_ptr;
    logic [bb3_pkg::Q_CW-1:0]     r_count;

    // Storage write.
    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr_ptr] <= i_push.item;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push.valid) begin
                r_wr_ptr <= r_wr_ptr + bb3_pkg::Q_AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + bb3_pkg::Q_AW'(1);
            end
            r_count <= r_count + bb3_pkg::Q_CW'(i_push.valid) - bb3_pkg::Q_CW'(i_pop);
        end
    end

    assign o_item             = r_mem[r_rd_ptr];
    assign o_status.count     = r_count;
    assign o_status.not_empty = (r_count != '0);

endmodule

`default_nettype wire

// ----- rtl/bb3_back.sv -----
// ============================================================================
// bb3_back: masked window sum and rounded mean
// Sums the in-image pixels of each job per channel, then divides by the
// pixel count with round-half-up through a reciprocal multiply.
// ============================================================================
`default_nettype none

module bb3_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bb3_pkg::t_q_status            i_q_status,
    input  bb3_pkg::t_blur_item           i_item,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [bb3_pkg::CH_W-1:0]      o_out_blue,
    output logic [bb3_pkg::CH_W-1:0]      o_out_green,
    output logic [bb3_pkg::CH_W-1:0]      o_out_red,
    output logic                          o_end_of_frame
);

    localparam int NCH = 3;

    // Sum stage.
    logic                                      r_b1_valid;
    logic [NCH-1:0][bb3_pkg::SUM_W-1:0]        r_b1_sum;
    logic [bb3_pkg::CNT_W-1:0]                 r_b1_n;
    logic                                      r_b1_eof;

    // Output register.
    logic                                      r_out_valid;
    logic [NCH-1:0][bb3_pkg::CH_W-1:0]         r_out_ch;
    logic                                      r_out_eof;

    logic                                      out_ready;
    logic                                      b1_ready;
    logic [NCH-1:0][bb3_pkg::SUM_W-1:0]        sum;
    logic [bb3_pkg::CNT_W-1:0]                 cnt;
    logic [1:0]                                rows;
    logic [1:0]                                cols;
    logic [bb3_pkg::RECIP_W-1:0]               k;
    logic [NCH-1:0][bb3_pkg::PROD_W-1:0]       prod;
    logic [NCH-1:0][bb3_pkg::CH_W-1:0]         mean;

    // Stage handshakes.
    assign out_ready = !r_out_valid || !i_stall;
    assign b1_ready  = !r_b1_valid || out_ready;
    assign o_pop     = i_q_status.not_empty && b1_ready;

    // Masked per-channel sums over the window.
    always_comb begin
        sum = '0;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                if (!((r == 0) && i_item.edges.top) && !((r == 2) && i_item.edges.bottom)
                    && !((c == 0) && i_item.edges.left) && !((c == 2) && i_item.edges.right))
                begin
                    for (int ch = 0; ch < NCH; ch++) begin
                        sum[ch] = sum[ch] + bb3_pkg::SUM_W'(
                            i_item.pix[r*3+c][ch*bb3_pkg::CH_W +: bb3_pkg::CH_W]);
                    end
                end
            end
        end
        rows = 2'd3 - 2'(i_item.edges.top) - 2'(i_item.edges.bottom);
        cols = 2'd3 - 2'(i_item.edges.left) - 2'(i_item.edges.right);
        cnt  = bb3_pkg::CNT_W'(rows) * bb3_pkg::CNT_W'(cols);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_valid <= 1'b0;
        end else if (b1_ready) begin
            r_b1_valid <= o_pop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_b1_sum <= sum;
            r_b1_n   <= cnt;
            r_b1_eof <= i_item.edges.bottom && i_item.edges.right;
        end
    end

    // Mean rounded half up: (S + floor(n/2)) / n by reciprocal multiply.
    always_comb begin
        k = bb3_pkg::recip(r_b1_n);
        for (int ch = 0; ch < NCH; ch++) begin
            prod[ch] = bb3_pkg::PROD_W'(r_b1_sum[ch] + bb3_pkg::SUM_W'(r_b1_n >> 1))
                       * bb3_pkg::PROD_W'(k);
            mean[ch] = prod[ch][bb3_pkg::RECIP_SHIFT +: bb3_pkg::CH_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= r_b1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ready && r_b1_valid) begin
            r_out_ch  <= mean;
            r_out_eof <= r_b1_eof;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_out_blue     = r_out_ch[0];
    assign o_out_green    = r_out_ch[1];
    assign o_out_red      = r_out_ch[2];
    assign o_end_of_frame = r_out_eof;

endmodule

`default_nettype wire

// ----- rtl/box_blur_3x3_top.sv -----
// ============================================================================
// box_blur_3x3_top: edge-normalized 3x3 box blur over a raster RGB stream
// Channel     Direction  Handshake          Payload
// pixel in    input      i_valid / o_stall  i_cmd, i_in_blue/green/red
// pixel out   output     o_valid / i_stall  o_out_blue/green/red, o_end_of_frame
// config      input      i_cfg_we           i_cfg_index, i_cfg_data
//
// One item per clock sustained while o_stall stays low; a result passes the
// line store read, the job queue, the sum and the output register in turn.
// The line store read-then-write at one column per cycle sets the rate.
// Reset clears counters, window and queue; the line stores need no clearing.
// On an output stall, o_stall rises once queued plus in-flight jobs reach four.
// ============================================================================
`default_nettype none

module box_blur_3x3_top #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [bb3_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [bb3_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic                              i_cmd,
    input  logic [bb3_pkg::CH_W-1:0]          i_in_blue,
    input  logic [bb3_pkg::CH_W-1:0]          i_in_green,
    input  logic [bb3_pkg::CH_W-1:0]          i_in_red,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [bb3_pkg::CH_W-1:0]          o_out_blue,
    output logic [bb3_pkg::CH_W-1:0]          o_out_green,
    output logic [bb3_pkg::CH_W-1:0]          o_out_red,
    output logic                              o_end_of_frame
);

    bb3_pkg::t_q_push     q_push;
    bb3_pkg::t_q_status   q_status;
    bb3_pkg::t_blur_item  q_item;
    logic                 q_pop;

    // Intake, line stores and window.
    bb3_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_cmd       (i_cmd),
        .i_in_blue   (i_in_blue),
        .i_in_green  (i_in_green),
        .i_in_red    (i_in_red),
        .i_q_status  (q_status),
        .o_push      (q_push)
    );

    // Job queue.
    bb3_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_pop    (q_pop),
        .o_status (q_status),
        .o_item   (q_item)
    );

    // Sum and mean.
    bb3_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_status     (q_status),
        .i_item         (q_item),
        .o_pop          (q_pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_out_blue     (o_out_blue),
        .o_out_green    (o_out_green),
        .o_out_red      (o_out_red),
        .o_end_of_frame (o_end_of_frame)
    );

endmodule

`default_nettype wire

// ----- rtl/bb3_checker.sv -----
// ============================================================================
// bb3_checker: port-level checks for the box blur
// Watches the top level's ports for output hold, reset state and the
// relation between input stall and pending results.
// ============================================================================
`default_nettype none

module bb3_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [bb3_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [bb3_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                              i_valid,
    input  logic                              o_stall,
    input  logic                              i_cmd,
    input  logic [bb3_pkg::CH_W-1:0]          i_in_blue,
    input  logic [bb3_pkg::CH_W-1:0]          i_in_green,
    input  logic [bb3_pkg::CH_W-1:0]          i_in_red,
    input  logic                              o_valid,
    input  logic                              i_stall,
    input  logic [bb3_pkg::CH_W-1:0]          o_out_blue,
    input  logic [bb3_pkg::CH_W-1:0]          o_out_green,
    input  logic [bb3_pkg::CH_W-1:0]          o_out_red,
    input  logic                              o_end_of_frame
);

    // A stalled result stays valid and unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out_blue) && $stable(o_out_green)
            && $stable(o_out_red) && $stable(o_end_of_frame))
        else $error("stalled output changed");

    // Reset leaves no result pending and the input open.
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("output or stall active after reset");

    // The input can only be stalled while a result waits at the output.
    a_stall_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("input stalled with no result pending");

    // The input stall only rises right after a transfer in.
    a_stall_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_stall) |-> $past(i_valid && !o_stall))
        else $error("input stall rose without a transfer");

endmodule

bind box_blur_3x3_top bb3_checker u_bb3_checker (.*);

`default_nettype wire

// ----- verif/tb_box_blur_3x3_top.sv -----
// ============================================================================
// tb_box_blur_3x3_top: self-checking testbench for the 3x3 box blur
// A short table of directed frames covers single-pixel images, rounding,
// pixels below the last row and a height change in mid-frame. Random frames
// of small sizes follow, plus one frame at the largest width and one at the largest height.
// Every transfer on the input feeds a local model of the blur, and each
// output transfer is compared field by field against the oldest prediction.
// ============================================================================

module tb_box_blur_3x3_top;

    timeunit 1ns;
    timeprecision 1ps;

    import bb3_pkg::*;

    localparam int MAX_W          = 2048;
    localparam int MAX_H          = 4096;
    localparam int RANDOM_ITEMS   = 550;
    localparam int DRAIN_CYCLES   = 8;
    localparam int HOLD_CYCLES    = 120;
    localparam int END_LIMIT      = 4000;
    localparam int DIR_ROWS       = 31;

    // One input item and one blurred pixel, as seen on the ports.
    typedef struct packed {
        logic            cmd;
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] red;
    } t_pix_item;

    typedef struct packed {
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] red;
        logic            eof;
    } t_blur_out;

    // Directed table: a register write or an item, with an optional
    // hand-computed result.
    typedef enum logic [1:0] {ROW_ITEM, ROW_WIDTH, ROW_HEIGHT} t_row_kind;

    typedef struct packed {
        t_row_kind              kind;
        logic [CFG_DATA_W-1:0]  cfg;
        logic                   cmd;
        logic [CH_W-1:0]        blue;
        logic [CH_W-1:0]        green;
        logic [CH_W-1:0]        red;
        logic                   typed;
        logic [CH_W-1:0]        want_blue;
        logic [CH_W-1:0]        want_green;
        logic [CH_W-1:0]        want_red;
        logic                   want_eof;
    } t_dir_row;

    typedef enum logic [1:0] {RX_FLOW, RX_LIGHT, RX_HEAVY} t_rx_mode;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] i_cfg_index = CFG_IMAGE_WIDTH;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;
    logic                   i_valid = 1'b0;
    logic                   o_stall;
    logic                   i_cmd = CMD_PIXEL;
    logic [CH_W-1:0]        i_in_blue = '0;
    logic [CH_W-1:0]        i_in_green = '0;
    logic [CH_W-1:0]        i_in_red = '0;
    logic                   o_valid;
    logic                   i_stall = 1'b0;
    logic [CH_W-1:0]        o_out_blue;
    logic [CH_W-1:0]        o_out_green;
    logic [CH_W-1:0]        o_out_red;
    logic                   o_end_of_frame;

    // Local copy of the block's registers and state.
    logic [WIDTH_REG_W-1:0]  blur_width = IMAGE_WIDTH_RST;
    logic [HEIGHT_REG_W-1:0] blur_height = IMAGE_HEIGHT_RST;
    t_pixel                  row_prev [MAX_W];
    t_pixel                  row_older [MAX_W];
    t_window                 blur_win = '0;
    int unsigned             in_col = 0;
    int unsigned             in_row = 0;
    int unsigned             out_col = 0;
    int unsigned             out_row = 0;
    bit                      frame_closed = 1'b0;

    t_blur_out   blurred_due [$];
    t_dir_row    dir_table [DIR_ROWS];
    int unsigned mismatch_count = 0;
    int unsigned results_checked = 0;
    int unsigned items_accepted = 0;
    int unsigned frames_run = 0;
    int unsigned cfg_writes = 0;
    int unsigned holds_done = 0;
    int unsigned burst_left = 0;
    bit          rx_hold_req = 1'b0;

    box_blur_3x3_top #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_cmd          (i_cmd),
        .i_in_blue      (i_in_blue),
        .i_in_green     (i_in_green),
        .i_in_red       (i_in_red),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_out_blue     (o_out_blue),
        .o_out_green    (o_out_green),
        .o_out_red      (o_out_red),
        .o_end_of_frame (o_end_of_frame)
    );

    // 12 ns clock.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // A register value of zero means one; values above the limit saturate.
    function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned lim);
        if (v == 0) return 1;
        if (v > lim) return lim;
        return v;
    endfunction

    // Advances the local blur state by one input item and returns 1 when the
    // item produces a blurred pixel.
    function automatic bit predict_blur_pixel(input t_pix_item it, output t_blur_out res);
        int unsigned w, h, n, sum_b, sum_g, sum_r, r, c;
        t_pixel      px, top, mid, v;
        bit          emit, top_e, bot_e, left_e, right_e;
        w = clamp_dim(blur_width, MAX_W);
        h = clamp_dim(blur_height, MAX_H);
        px = (it.cmd == CMD_PIXEL) ? {it.red, it.green, it.blue} : '0;
        top = '0;
        mid = '0;
        if (in_col < MAX_W) begin
            top = row_older[in_col];
            mid = row_prev[in_col];
            row_older[in_col] = mid;
            row_prev[in_col] = px;
        end

        // Shift the window left and load the new right column.
        for (r = 0; r < 3; r++) begin
            blur_win[r*3] = blur_win[r*3+1];
            blur_win[r*3+1] = blur_win[r*3+2];
        end
        blur_win[2] = top;
        blur_win[5] = mid;
        blur_win[8] = px;

        emit = (in_row >= 2) || (in_row == 1 && in_col >= 1);
        if (in_col + 1 >= w) begin
            in_col = 0;
            if (in_row < MAX_H + 1) in_row++;
        end else begin
            in_col++;
        end

        res = '0;
        if (!emit) return 1'b0;

        // Sum only the neighbors that lie inside the image.
        top_e = (out_row == 0);
        bot_e = (out_row + 1 >= h);
        left_e = (out_col == 0);
        right_e = (out_col + 1 >= w);
        sum_b = 0;
        sum_g = 0;
        sum_r = 0;
        n = 0;
        for (r = 0; r < 3; r++) begin
            for (c = 0; c < 3; c++) begin
                if (!((r == 0 && top_e) || (r == 2 && bot_e) ||
                      (c == 0 && left_e) || (c == 2 && right_e))) begin
                    v = blur_win[r*3+c];
                    sum_b += v[7:0];
                    sum_g += v[15:8];
                    sum_r += v[23:16];
                    n++;
                end
            end
        end

        // Mean rounded half up.
        res.blue = CH_W'((2 * sum_b + n) / (2 * n));
        res.green = CH_W'((2 * sum_g + n) / (2 * n));
        res.red = CH_W'((2 * sum_r + n) / (2 * n));
        res.eof = bot_e && right_e;

        if (res.eof) begin
            in_col = 0;
            in_row = 0;
            out_col = 0;
            out_row = 0;
            frame_closed = 1'b1;
        end else if (right_e) begin
            out_col = 0;
            out_row++;
        end else begin
            out_col++;
        end
        return 1'b1;
    endfunction

    task automatic report_error(input string msg);
        mismatch_count++;
        $display("ERROR at %0t ns: %s", $time, msg);
    endtask

    // Offers one item in bursts with random gaps, then records the
    // prediction once the transfer has happened.
    task automatic offer_item(input t_pix_item it, input bit typed, input t_blur_out typed_want);
        t_blur_out predicted;
        bit        emits;
        @(negedge i_clk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 32);
            if ($urandom_range(0, 2) != 0) begin
                i_valid = 1'b0;
                repeat ($urandom_range(1, 10)) @(negedge i_clk);
            end
        end
        burst_left--;
        i_valid = 1'b1;
        i_cmd = it.cmd;
        i_in_blue = it.blue;
        i_in_green = it.green;
        i_in_red = it.red;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        emits = predict_blur_pixel(it, predicted);
        if (typed) blurred_due.push_back(typed_want);
        else if (emits) blurred_due.push_back(predicted);
        items_accepted++;
    endtask

    // Stops offering and waits until every predicted pixel has come out.
    task automatic wait_until_drained();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (blurred_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = val;
        if (idx == CFG_IMAGE_WIDTH) blur_width = val[WIDTH_REG_W-1:0];
        else blur_height = val[HEIGHT_REG_W-1:0];
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // One frame of random pixels with occasional flush items inside it, then
    // trailing items, mostly flushes, until the frame closes. Some frames are cut
    // short and closed by the trailing items; some pause until the output has drained.
    task automatic run_frame();
        int unsigned n_pix, cut_at, pause_at, k;
        t_pix_item   it;
        n_pix = clamp_dim(blur_width, MAX_W) * clamp_dim(blur_height, MAX_H);
        cut_at = ($urandom_range(0, 7) == 0) ? $urandom_range(0, n_pix - 1) : n_pix;
        pause_at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, n_pix - 1) : n_pix;
        if (frames_run == 0 || $urandom_range(0, 5) == 0) rx_hold_req = 1'b1;
        frame_closed = 1'b0;
        for (k = 0; k < cut_at; k++) begin
            if (k == pause_at) wait_until_drained();
            it.cmd = ($urandom_range(0, 24) == 0) ? CMD_FLUSH : CMD_PIXEL;
            it.blue = $urandom_range(0, 255);
            it.green = $urandom_range(0, 255);
            it.red = $urandom_range(0, 255);
            offer_item(it, 1'b0, '0);
        end
        while (!frame_closed) begin
            it.cmd = ($urandom_range(0, 5) == 0) ? CMD_PIXEL : CMD_FLUSH;
            it.blue = $urandom_range(0, 255);
            it.green = $urandom_range(0, 255);
            it.red = $urandom_range(0, 255);
            offer_item(it, 1'b0, '0);
        end
        frames_run++;
    endtask

    // Receiver stall pattern: stretches of free flow, light and heavy
    // stalling, and a long hold-off whenever one is requested.
    initial begin : stall_pattern
        t_rx_mode    mode;
        int unsigned mode_left, hold_left;
        mode = RX_FLOW;
        mode_left = 0;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_left != 0) begin
                hold_left--;
                i_stall = 1'b1;
            end else if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                hold_left = HOLD_CYCLES - 1;
                holds_done++;
                i_stall = 1'b1;
            end else begin
                if (mode_left == 0) begin
                    mode = t_rx_mode'($urandom_range(0, 2));
                    mode_left = $urandom_range(4, 48);
                end
                mode_left--;
                case (mode)
                    RX_FLOW:  i_stall = 1'b0;
                    RX_LIGHT: i_stall = ($urandom_range(0, 3) == 0);
                    default:  i_stall = ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    // Output checker: each transfer against the oldest prediction.
    always @(posedge i_clk) begin : check_output
        t_blur_out want;
        if (i_rst_n && o_valid === 1'b1 && !i_stall) begin
            results_checked++;
            if (blurred_due.size() == 0) begin
                report_error("blurred pixel with no prediction pending");
            end else begin
                want = blurred_due.pop_front();
                if (o_out_blue !== want.blue)
                    report_error($sformatf("blue got %0d want %0d", o_out_blue, want.blue));
                if (o_out_green !== want.green)
                    report_error($sformatf("green got %0d want %0d", o_out_green, want.green));
                if (o_out_red !== want.red)
                    report_error($sformatf("red got %0d want %0d", o_out_red, want.red));
                if (o_end_of_frame !== want.eof)
                    report_error($sformatf("end_of_frame got %b want %b",
                                           o_end_of_frame, want.eof));
            end
        end
    end

    // Run time limit.
    initial begin : watchdog
        #10_000_000;
        $display("tb_box_blur_3x3_top failed");
        $finish;
    end

    // Main sequence.
    initial begin : stimulus
        int unsigned k, start_items, end_wait, w_pick, h_pick, n_frames;
        t_dir_row    row;
        t_pix_item   it;
        t_blur_out   want;

        // Directed frames. Zero registers act as 1x1; a pixel below the last
        // row is masked; 0/1, 0/255 and 255/254 pairs check rounding; the
        // last frame changes its height halfway through.
        dir_table = '{
            '{ROW_WIDTH,  13'd0, CMD_PIXEL, 8'd0,   8'd0,   8'd0,   1'b0, 8'd0, 8'd0, 8'd0, 1'b0},
            '{ROW_HEIGHT, 13'd0, CMD_PIXEL, 8'd0,   8'd0,   8'd0,   1'b0, 8'd0, 8'd0, 8'd0, 1'b0},
            '{ROW_ITEM,   13'd0, CMD_PIXEL, 8'd255, 8'd255, 8'd255, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0},
            '{ROW_ITEM,   13'd0, CMD_FLUSH, 8'd0,   8'd0,   8'd0,   1'b0, 8'd0, 8'd0, 8'd0, 1'b0},
            '{ROW_ITEM,   13'd0, CMD_FLUSH, 8'd0,   8'd0,   8'd0,
              1'b1, 8'd255, 8'd255, 8'd255, 1'b1},
            '{ROW_ITEM,   13'd0, CMD_PIXEL, 8'd0,   8'd0,   8'd0,   1'b0, 8'd0, 8'd0, 8'd0, 1'b0},
            '{ROW_ITEM,   13'd0, CMD_FLUSH, 8'd0,   8'd0,   8'd0,   1'b0, 8'd0, 8'd0, 8'd0, 1'b0},
            '{ROW_ITEM,   13'd0, CMD_FLUSH, 8'd0,   8'd0,   8'd0,   1'b1, 8'd0, 8'd0, 8'd0, 1'b1},
            '{ROW_ITEM,   13'd0, CMD_PIXEL, 8'hAA,  8'h55,  8'h0F,  1'b0, 8'd0, 8'd0, 8'd0, 1'b0},
            '{ROW_ITEM,   13'd0, CMD_PIXEL, 8'hFF,  8'hFF,  8'hFF,  1'b0, 8'd0, 8'd0, 8'd0, 1'b0},
            '{ROW_ITEM,   13'd0, CMD_FLUSH, 8'd0,   8'd0,   8'd0,
              1'b1, 8'hAA, 8'h55, 8'h0F, 1'b1},
            '{ROW_WIDTH,  13'd2, CMD_PIXEL, 8'd0,   8'd0,   8'd0,   1'b0, 8'd0, 8'd0, 8'd0, 1'b0},
            '{ROW_HEIGHT, 13'd1, CMD_PIXEL, 8'd0,   8'd0,   8'd0,   1'b0, 8'd0, 8'd0, 8'd0, 1'b0},
            '{ROW_ITEM,   13'd0, CMD_PIXEL, 8'd0,   8'd0,   8'd255, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0},
            '{ROW_ITEM,   13'd0, CMD_PIXEL, 8'd1,   8'd255, 8'd254, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0},
            '{ROW_ITEM,   13'd0, CMD_FLUSH, 8'd0,   8'd0,   8'd0,   1'b0, 8'd0, 8'd0, 8'd0, 1'b0},
            '{ROW_ITEM,   13'd0, CMD_FLUSH, 8'd0,   8'd0,   8'd0,
              1'b1, 8'd1, 8'd128, 8'd255, 1'b0},
            '{ROW_ITEM,   13'd0, CMD_FLUSH, 8'd0,   8'd0,   8'd0,
              1'b1, 8'd1, 8'd128, 8'd255, 1'b1},
            '{ROW_WIDTH,  13'd3, CMD_PIXEL, 8'd0,   8'd0,   8'd0,   1'b0, 8'd0, 8'd0, 8'd0, 1'b0},
            '{ROW_HEIGHT, 13'd4, CMD_PIXEL, 8'd0,   8'd0,   8'd0,   1'b0, 8'd0, 8'd0, 8'd0, 1'b0},
            '{ROW_ITEM,   13'd0, CMD_PIXEL, 8'd10,  8'd20,  8'd30,  1'b0, 8'd0, 8'd0, 8'd0, 1'b0},
            '{ROW_ITEM,   13'd0, CMD_PIXEL, 8'd200, 8'd100, 8'd50,  1'b0, 8'd0, 8'd0, 8'd0, 1'b0},
            '{ROW_ITEM,   13'd0, CMD_PIXEL, 8'd255, 8'd0,   8'd128, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0},
            '{ROW_ITEM,   13'd0, CMD_PIXEL, 8'd7,   8'd250, 8'd3,   1'b0, 8'd0, 8'd0, 8'd0, 1'b0},
            '{ROW_ITEM,   13'd0, CMD_PIXEL, 8'd99,  8'd1,   8'd254, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0},
            '{ROW_ITEM,   13'd0, CMD_PIXEL, 8'd64,  8'd192, 8'd17,  1'b0, 8'd0, 8'd0, 8'd0, 1'b0},
            '{ROW_HEIGHT, 13'd2, CMD_PIXEL, 8'd0,   8'd0,   8'd0,   1'b0, 8'd0, 8'd0, 8'd0, 1'b0},
            '{ROW_ITEM,   13'd0, CMD_FLUSH, 8'd0,   8'd0,   8'd0,   1'b0, 8'd0, 8'd0, 8'd0, 1'b0},
            '{ROW_ITEM,   13'd0, CMD_FLUSH, 8'd0,   8'd0,   8'd0,   1'b0, 8'd0, 8'd0, 8'd0, 1'b0},
            '{ROW_ITEM,   13'd0, CMD_FLUSH, 8'd0,   8'd0,   8'd0,   1'b0, 8'd0, 8'd0, 8'd0, 1'b0},
            '{ROW_ITEM,   13'd0, CMD_FLUSH, 8'd0,   8'd0,   8'd0,   1'b0, 8'd0, 8'd0, 8'd0, 1'b0}
        };

        // Reset once, synchronous.
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (k = 0; k < DIR_ROWS; k++) begin
            row = dir_table[k];
            case (row.kind)
                ROW_WIDTH: begin
                    wait_until_drained();
                    write_cfg(CFG_IMAGE_WIDTH, row.cfg);
                end
                ROW_HEIGHT: begin
                    wait_until_drained();
                    write_cfg(CFG_IMAGE_HEIGHT, row.cfg);
                end
                default: begin
                    it.cmd = row.cmd;
                    it.blue = row.blue;
                    it.green = row.green;
                    it.red = row.red;
                    want.blue = row.want_blue;
                    want.green = row.want_green;
                    want.red = row.want_red;
                    want.eof = row.want_eof;
                    offer_item(it, row.typed, want);
                end
            endcase
        end

        // Largest frames: all-ones registers saturate at the width and height
        // limits, kept to a single row or a single column.
        wait_until_drained();
        write_cfg(CFG_IMAGE_WIDTH, 13'h0FFF);
        write_cfg(CFG_IMAGE_HEIGHT, 13'd1);
        run_frame();
        wait_until_drained();
        write_cfg(CFG_IMAGE_WIDTH, 13'd1);
        write_cfg(CFG_IMAGE_HEIGHT, 13'h1FFF);
        run_frame();

        // Random small frames. Registers only change on a frame boundary
        // and with the output drained.
        start_items = items_accepted;
        while (items_accepted - start_items < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0:       w_pick = 0;
                1:       w_pick = 1;
                2:       w_pick = 2;
                default: w_pick = $urandom_range(3, 12);
            endcase
            case ($urandom_range(0, 7))
                0:       h_pick = 0;
                1:       h_pick = 1;
                default: h_pick = $urandom_range(2, 6);
            endcase
            wait_until_drained();
            write_cfg(CFG_IMAGE_WIDTH, CFG_DATA_W'(w_pick));
            write_cfg(CFG_IMAGE_HEIGHT, CFG_DATA_W'(h_pick));
            n_frames = $urandom_range(1, 2);
            repeat (n_frames) run_frame();
        end

        // Let the output drain, bounded.
        @(negedge i_clk);
        i_valid = 1'b0;
        for (end_wait = 0; end_wait < END_LIMIT && blurred_due.size() != 0; end_wait++)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (blurred_due.size() != 0)
            report_error($sformatf("%0d predicted pixels never came out", blurred_due.size()));

        $display("Covered %0d input transfers in %0d random or large frames, %0d register writes,",
                 items_accepted, frames_run, cfg_writes);
        $display("%0d long output hold-offs; %0d blurred pixels checked, %0d mismatches.",
                 holds_done, results_checked, mismatch_count);
        if (mismatch_count == 0) begin
            $display("tb_box_blur_3x3_top passed");
        end else begin
            $display("tb_box_blur_3x3_top failed");
        end
        $finish;
    end

endmodule
